/* src/bldt_pkg.sv */
// Shared types, widths and constants for the battery level display tracker.
// No dependencies; every other file of the block refers to this package by scoped names.

package bldt_pkg;

    localparam int MV_W   = 13;
    localparam int CNT_W  = 14;
    localparam int LVL_W  = 7;
    localparam int SEG_W  = 7;
    localparam int IDX_W  = 3;
    localparam int DATA_W = 14;

    localparam logic [LVL_W-1:0] LEVEL_MAX  = 7'd99;
    localparam logic [LVL_W-1:0] KNEE_LEVEL = 7'd20;
    localparam logic [LVL_W-1:0] EMPTY_LEVEL = 7'd1;

    // Low segment divides by 80: shift right by 4, then divide by 5.
    localparam int LOW_STEP_SHIFT = 4;
    // n / 5 == (n * 205) >> 10 for n below 1024.
    localparam logic [7:0] DIV5_MULT  = 8'd205;
    localparam int         DIV5_SHIFT = 10;
    // n / 10 == (n * 205) >> 11 for n below 128.
    localparam int         DIV10_SHIFT = 11;
    // Above the knee, an offset of this many millivolts or more always caps at 99.
    localparam logic [MV_W-1:0] HIGH_SPAN_MV = 13'd400;

    localparam logic [MV_W-1:0]  RST_EMPTY_MV       = 13'd2800;
    localparam logic [MV_W-1:0]  RST_KNEE_MV        = 13'd3600;
    localparam logic [CNT_W-1:0] RST_FULL_RISE      = 14'd7500;
    localparam logic [CNT_W-1:0] RST_CHARGE_RISE    = 14'd15000;
    localparam logic [CNT_W-1:0] RST_SLOW_FALL      = 14'd15000;
    localparam logic [CNT_W-1:0] RST_FAST_FALL      = 14'd8000;
    localparam logic [LVL_W-1:0] RST_FAST_FALL_BELOW = 7'd40;

    typedef enum logic [IDX_W-1:0] {
        REG_EMPTY_MV        = 3'd0,
        REG_KNEE_MV         = 3'd1,
        REG_FULL_RISE       = 3'd2,
        REG_CHARGE_RISE     = 3'd3,
        REG_SLOW_FALL       = 3'd4,
        REG_FAST_FALL       = 3'd5,
        REG_FAST_FALL_BELOW = 3'd6
    } reg_index_t;

    typedef struct packed {
        logic [MV_W-1:0]  empty_mv;
        logic [MV_W-1:0]  knee_mv;
        logic [CNT_W-1:0] full_rise;
        logic [CNT_W-1:0] charge_rise;
        logic [CNT_W-1:0] slow_fall;
        logic [CNT_W-1:0] fast_fall;
        logic [LVL_W-1:0] fast_fall_below;
    } cfg_t;

    typedef struct packed {
        logic [MV_W-1:0] supply_millivolts;
        logic            charging;
        logic            charge_full;
        logic            low_lock;
        logic            ten_second_mark;
    } item_t;

    // Seven-segment pattern gfedcba; digits above 9 are blank.
    function automatic logic [SEG_W-1:0] seg_pattern(input logic [3:0] digit);
        logic [SEG_W-1:0] seg;
        case (digit)
            4'd0:    seg = 7'h3f;
            4'd1:    seg = 7'h06;
            4'd2:    seg = 7'h5b;
            4'd3:    seg = 7'h4f;
            4'd4:    seg = 7'h66;
            4'd5:    seg = 7'h6d;
            4'd6:    seg = 7'h7d;
            4'd7:    seg = 7'h07;
            4'd8:    seg = 7'h7f;
            4'd9:    seg = 7'h6f;
            default: seg = 7'h00;
        endcase
        return seg;
    endfunction

endpackage

/* src/bldt_if.sv */
// Valid/ready channel interfaces for the battery level display tracker.
// Depends on bldt_pkg for field widths.

interface bldt_in_if;
    logic                      valid;
    logic                      ready;
    logic [bldt_pkg::MV_W-1:0] supply_millivolts;
    logic                      charging;
    logic                      charge_full;
    logic                      low_lock;
    logic                      ten_second_mark;

    modport source (output valid, supply_millivolts, charging, charge_full, low_lock,
                    ten_second_mark, input ready);
    modport sink (input valid, supply_millivolts, charging, charge_full, low_lock,
                  ten_second_mark, output ready);
endinterface

interface bldt_out_if;
    logic                       valid;
    logic                       ready;
    logic [bldt_pkg::LVL_W-1:0] shown_level;
    logic [bldt_pkg::LVL_W-1:0] measured_level;
    logic [bldt_pkg::SEG_W-1:0] tens_segments;
    logic [bldt_pkg::SEG_W-1:0] ones_segments;

    modport source (output valid, shown_level, measured_level, tens_segments, ones_segments,
                    input ready);
    modport sink (input valid, shown_level, measured_level, tens_segments, ones_segments,
                  output ready);
endinterface

interface bldt_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [bldt_pkg::IDX_W-1:0]  index;
    logic [bldt_pkg::DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

/* src/bldt_cfg_regs.sv */
// Configuration register file of the battery level display tracker.
// Depends on bldt_pkg and bldt_cfg_if; writes to unknown indexes are dropped.

module bldt_cfg_regs (
    input  logic            clk,
    input  logic            rst_n,
    bldt_cfg_if.sink        cfg_ch,
    output bldt_pkg::cfg_t  cfg
);

    bldt_pkg::cfg_t cfg_reg;
    logic           wr_en;

    assign cfg_ch.ready = 1'b1;
    assign wr_en        = cfg_ch.valid;
    assign cfg          = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.empty_mv        <= bldt_pkg::RST_EMPTY_MV;
            cfg_reg.knee_mv         <= bldt_pkg::RST_KNEE_MV;
            cfg_reg.full_rise       <= bldt_pkg::RST_FULL_RISE;
            cfg_reg.charge_rise     <= bldt_pkg::RST_CHARGE_RISE;
            cfg_reg.slow_fall       <= bldt_pkg::RST_SLOW_FALL;
            cfg_reg.fast_fall       <= bldt_pkg::RST_FAST_FALL;
            cfg_reg.fast_fall_below <= bldt_pkg::RST_FAST_FALL_BELOW;
        end
        else if (wr_en)
        begin
            case (cfg_ch.index)
                bldt_pkg::REG_EMPTY_MV:
                    cfg_reg.empty_mv <= cfg_ch.data[bldt_pkg::MV_W-1:0];
                bldt_pkg::REG_KNEE_MV:
                    cfg_reg.knee_mv <= cfg_ch.data[bldt_pkg::MV_W-1:0];
                bldt_pkg::REG_FULL_RISE:
                    cfg_reg.full_rise <= cfg_ch.data[bldt_pkg::CNT_W-1:0];
                bldt_pkg::REG_CHARGE_RISE:
                    cfg_reg.charge_rise <= cfg_ch.data[bldt_pkg::CNT_W-1:0];
                bldt_pkg::REG_SLOW_FALL:
                    cfg_reg.slow_fall <= cfg_ch.data[bldt_pkg::CNT_W-1:0];
                bldt_pkg::REG_FAST_FALL:
                    cfg_reg.fast_fall <= cfg_ch.data[bldt_pkg::CNT_W-1:0];
                bldt_pkg::REG_FAST_FALL_BELOW:
                    cfg_reg.fast_fall_below <= cfg_ch.data[bldt_pkg::LVL_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

endmodule

/* src/bldt_level_map.sv */
// Piecewise voltage-to-level mapping of the battery level display tracker.
// Depends on bldt_pkg; purely combinational, divides by 80 and 5 with reciprocal multiplies.

module bldt_level_map (
    input  logic [bldt_pkg::MV_W-1:0]  supply_millivolts,
    input  bldt_pkg::cfg_t             cfg,
    output logic                       below_empty,
    output logic [bldt_pkg::LVL_W-1:0] level
);

    logic [bldt_pkg::MV_W-1:0]  low_x;
    logic [8:0]                 low_y;
    logic [16:0]                low_prod;
    logic [bldt_pkg::LVL_W-1:0] low_level;
    logic [bldt_pkg::MV_W-1:0]  high_x;
    logic [16:0]                high_prod;
    logic [bldt_pkg::LVL_W-1:0] high_level;

    assign below_empty = supply_millivolts < cfg.empty_mv;

    // Between empty and knee: (mv - empty) / 80, capped.
    assign low_x     = supply_millivolts - cfg.empty_mv;
    assign low_y     = low_x[bldt_pkg::MV_W-1:bldt_pkg::LOW_STEP_SHIFT];
    assign low_prod  = {8'd0, low_y} * {9'd0, bldt_pkg::DIV5_MULT};
    assign low_level = (low_prod[16:bldt_pkg::DIV5_SHIFT] > bldt_pkg::LEVEL_MAX)
                       ? bldt_pkg::LEVEL_MAX : low_prod[16:bldt_pkg::DIV5_SHIFT];

    // At or above the knee: 20 + (mv - knee) / 5. Large offsets saturate directly,
    // so only the low nine bits need the reciprocal multiply.
    assign high_x     = supply_millivolts - cfg.knee_mv;
    assign high_prod  = {8'd0, high_x[8:0]} * {9'd0, bldt_pkg::DIV5_MULT};
    assign high_level = (high_x >= bldt_pkg::HIGH_SPAN_MV) ? bldt_pkg::LEVEL_MAX
                        : bldt_pkg::KNEE_LEVEL + high_prod[16:bldt_pkg::DIV5_SHIFT];

    assign level = (supply_millivolts < cfg.knee_mv) ? low_level : high_level;

endmodule

/* src/bldt_tracker.sv */
// Displayed-level state, rise and fall counters and digit decode of the tracker.
// Depends on bldt_pkg; state advances once per word taken from the input register.

module bldt_tracker (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       step,
    input  bldt_pkg::item_t            item,
    input  logic                       below_empty,
    input  logic [bldt_pkg::LVL_W-1:0] mapped_level,
    input  bldt_pkg::cfg_t             cfg,
    output logic [bldt_pkg::LVL_W-1:0] shown_level,
    output logic [bldt_pkg::LVL_W-1:0] measured_level,
    output logic [bldt_pkg::SEG_W-1:0] tens_segments,
    output logic [bldt_pkg::SEG_W-1:0] ones_segments
);

    logic [bldt_pkg::LVL_W-1:0] displayed_reg, displayed_next;
    logic [bldt_pkg::LVL_W-1:0] measured_reg, measured_next;
    logic [bldt_pkg::CNT_W-1:0] full_cnt_reg, full_cnt_next;
    logic [bldt_pkg::CNT_W-1:0] slew_cnt_reg, slew_cnt_next;

    logic [bldt_pkg::CNT_W:0]   full_inc;
    logic [bldt_pkg::CNT_W:0]   slew_inc;
    logic [bldt_pkg::LVL_W-1:0] after_full;
    logic [bldt_pkg::CNT_W-1:0] fall_period;
    logic [14:0]                tens_prod;
    logic [3:0]                 tens_digit;
    logic [bldt_pkg::LVL_W-1:0] ones_value;

    assign full_inc    = {1'b0, full_cnt_reg} + 15'd1;
    assign slew_inc    = {1'b0, slew_cnt_reg} + 15'd1;
    assign fall_period = (displayed_reg < cfg.fast_fall_below) ? cfg.fast_fall : cfg.slow_fall;

    always_comb
    begin
        displayed_next = displayed_reg;
        measured_next  = measured_reg;
        full_cnt_next  = full_cnt_reg;
        slew_cnt_next  = slew_cnt_reg;
        after_full     = displayed_reg;

        if (item.low_lock)
        begin
            displayed_next = '0;
            measured_next  = '0;
        end
        else if (below_empty)
        begin
            // Empty: counters hold, ten-second marks drop the display unless charging.
            measured_next = bldt_pkg::EMPTY_LEVEL;
            if (item.ten_second_mark)
            begin
                if (displayed_reg > bldt_pkg::EMPTY_LEVEL)
                begin
                    if (!item.charging)
                        displayed_next = displayed_reg - 7'd1;
                end
                else
                begin
                    displayed_next = bldt_pkg::EMPTY_LEVEL;
                end
            end
        end
        else
        begin
            measured_next = mapped_level;
            if (item.charging)
            begin
                if (item.charge_full && displayed_reg < bldt_pkg::LEVEL_MAX)
                begin
                    if (full_inc >= {1'b0, cfg.full_rise})
                    begin
                        full_cnt_next = '0;
                        after_full    = displayed_reg + 7'd1;
                    end
                    else
                    begin
                        full_cnt_next = full_inc[bldt_pkg::CNT_W-1:0];
                    end
                end
                else
                begin
                    full_cnt_next = '0;
                end

                // The charge rise sees the level as already raised by the full rise.
                displayed_next = after_full;
                if (mapped_level > after_full)
                begin
                    if (slew_inc >= {1'b0, cfg.charge_rise} && after_full < bldt_pkg::LEVEL_MAX)
                    begin
                        slew_cnt_next  = '0;
                        displayed_next = after_full + 7'd1;
                    end
                    else
                    begin
                        slew_cnt_next = slew_inc[bldt_pkg::CNT_W-1:0];
                    end
                end
                else
                begin
                    slew_cnt_next = '0;
                end
            end
            else
            begin
                if (mapped_level < displayed_reg && displayed_reg > bldt_pkg::EMPTY_LEVEL)
                begin
                    if (slew_inc >= {1'b0, fall_period})
                    begin
                        slew_cnt_next  = '0;
                        displayed_next = displayed_reg - 7'd1;
                    end
                    else
                    begin
                        slew_cnt_next = slew_inc[bldt_pkg::CNT_W-1:0];
                    end
                end
                else
                begin
                    slew_cnt_next = '0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            displayed_reg <= '0;
            measured_reg  <= '0;
            full_cnt_reg  <= '0;
            slew_cnt_reg  <= '0;
        end
        else if (step)
        begin
            displayed_reg <= displayed_next;
            measured_reg  <= measured_next;
            full_cnt_reg  <= full_cnt_next;
            slew_cnt_reg  <= slew_cnt_next;
        end
    end

    // Tens digit by reciprocal multiply, ones digit as the remainder.
    assign tens_prod  = {8'd0, displayed_next} * {7'd0, bldt_pkg::DIV5_MULT};
    assign tens_digit = tens_prod[14:bldt_pkg::DIV10_SHIFT];
    assign ones_value = displayed_next - 7'(tens_digit * 4'd10);

    assign shown_level    = displayed_next;
    assign measured_level = measured_next;
    assign tens_segments  = bldt_pkg::seg_pattern(tens_digit);
    assign ones_segments  = bldt_pkg::seg_pattern(ones_value[3:0]);

endmodule

/* src/battery_level_display_tracker.sv */
// Battery level display tracker: input register, level mapping, tracker state, result register.
// Depends on bldt_pkg, bldt_if, bldt_cfg_regs, bldt_level_map and bldt_tracker.
// A word taken into the input register passes the level mapping and tracker into the result register.
// Throughput: one word per cycle while the sink is ready; the tracker state updates in the same cycle it is read.
// While a finished result waits for the sink, the input register takes one more word and holds.
// Reset clears both levels and counters to zero and loads the register defaults; no warm-up.

module battery_level_display_tracker (
    input  logic         clk,
    input  logic         rst_n,
    bldt_in_if.sink      in_ch,
    bldt_out_if.source   out_ch,
    bldt_cfg_if.sink     cfg_ch
);

    bldt_pkg::cfg_t  cfg;
    bldt_pkg::item_t in_item_reg;
    logic            in_valid_reg;
    logic            out_valid_reg;
    logic            advance;

    logic                       below_empty;
    logic [bldt_pkg::LVL_W-1:0] mapped_level;
    logic [bldt_pkg::LVL_W-1:0] shown_level;
    logic [bldt_pkg::LVL_W-1:0] measured_level;
    logic [bldt_pkg::SEG_W-1:0] tens_segments;
    logic [bldt_pkg::SEG_W-1:0] ones_segments;

    logic [bldt_pkg::LVL_W-1:0] shown_reg;
    logic [bldt_pkg::LVL_W-1:0] measured_reg;
    logic [bldt_pkg::SEG_W-1:0] tens_reg;
    logic [bldt_pkg::SEG_W-1:0] ones_reg;

    assign advance     = in_valid_reg && (!out_valid_reg || out_ch.ready);
    assign in_ch.ready = !in_valid_reg || advance;

    bldt_cfg_regs u_cfg_regs (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg_ch (cfg_ch),
        .cfg    (cfg)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_ch.ready)
            in_valid_reg <= in_ch.valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ch.valid && in_ch.ready)
        begin
            in_item_reg.supply_millivolts <= in_ch.supply_millivolts;
            in_item_reg.charging          <= in_ch.charging;
            in_item_reg.charge_full       <= in_ch.charge_full;
            in_item_reg.low_lock          <= in_ch.low_lock;
            in_item_reg.ten_second_mark   <= in_ch.ten_second_mark;
        end
    end

    bldt_level_map u_level_map (
        .supply_millivolts (in_item_reg.supply_millivolts),
        .cfg               (cfg),
        .below_empty       (below_empty),
        .level             (mapped_level)
    );

    bldt_tracker u_tracker (
        .clk            (clk),
        .rst_n          (rst_n),
        .step           (advance),
        .item           (in_item_reg),
        .below_empty    (below_empty),
        .mapped_level   (mapped_level),
        .cfg            (cfg),
        .shown_level    (shown_level),
        .measured_level (measured_level),
        .tens_segments  (tens_segments),
        .ones_segments  (ones_segments)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (out_ch.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            shown_reg    <= shown_level;
            measured_reg <= measured_level;
            tens_reg     <= tens_segments;
            ones_reg     <= ones_segments;
        end
    end

    assign out_ch.valid          = out_valid_reg;
    assign out_ch.shown_level    = shown_reg;
    assign out_ch.measured_level = measured_reg;
    assign out_ch.tens_segments  = tens_reg;
    assign out_ch.ones_segments  = ones_reg;

    // A word waiting in the input register must not vanish while the output is stalled.
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !advance) |=> in_valid_reg)
        else $error("input word dropped while stalled");

    // A locked word always reports both levels as zero.
    a_lock_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && in_item_reg.low_lock) |=>
            (out_ch.shown_level == '0 && out_ch.measured_level == '0))
        else $error("low lock did not force levels to zero");

    // An empty supply without lock reports a measured level of one.
    a_empty_level: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && !in_item_reg.low_lock && below_empty) |=>
            (out_ch.measured_level == bldt_pkg::EMPTY_LEVEL))
        else $error("empty supply measured level is not one");

    // The displayed level never leaves the range of two digits.
    a_shown_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> (out_ch.shown_level <= bldt_pkg::LEVEL_MAX))
        else $error("displayed level above 99");

endmodule

/* bench/tb.sv */
`timescale 1ns / 1ps
// Self-checking bench for battery_level_display_tracker: random and directed voltage readings.
// Depends on bldt_pkg, the channel interfaces in bldt_if and the block's top level.

module tb;

    localparam int LOW_MV_PER_LEVEL  = 80;
    localparam int HIGH_MV_PER_LEVEL = 5;
    localparam int MV_TOP            = 8191;
    localparam int PERIOD_TOP        = 16383;
    localparam int SETTLE_CYCLES     = 6;
    localparam int PHASE_READINGS    = 150;
    localparam int MAX_PRINTED       = 60;
    localparam logic [bldt_pkg::IDX_W-1:0] REG_UNUSED = 3'd7;

    // Segment patterns gfedcba for the digits 0 to 9.
    localparam logic [bldt_pkg::SEG_W-1:0] DIGIT_SEGS [0:9] = '{
        7'h3f, 7'h06, 7'h5b, 7'h4f, 7'h66, 7'h6d, 7'h7d, 7'h07, 7'h7f, 7'h6f
    };

    typedef struct packed {
        logic [bldt_pkg::LVL_W-1:0] shown;
        logic [bldt_pkg::LVL_W-1:0] measured;
        logic [bldt_pkg::SEG_W-1:0] tens;
        logic [bldt_pkg::SEG_W-1:0] ones;
    } gauge_t;

    logic clk = 1'b0;
    logic rst_n;

    bldt_in_if  in_ch ();
    bldt_out_if out_ch ();
    bldt_cfg_if cfg_ch ();

    battery_level_display_tracker dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch),
        .cfg_ch (cfg_ch)
    );

    always #4 clk = ~clk;

    // Predictor state and register copy.
    bldt_pkg::cfg_t             tracker_cfg;
    logic [bldt_pkg::LVL_W-1:0] shown_state;
    logic [bldt_pkg::LVL_W-1:0] measured_state;
    logic [bldt_pkg::CNT_W-1:0] full_ticks;
    logic [bldt_pkg::CNT_W-1:0] slew_ticks;

    gauge_t expected_gauges[$];

    int  mismatches = 0;
    int  words_checked = 0;
    int  readings_sent = 0;
    int  settings_used = 0;
    int  lock_count = 0;
    int  empty_count = 0;
    int  rise_count = 0;
    int  fall_count = 0;
    bit  gaps_on = 1'b1;
    bit  stalls_on = 1'b1;

    function automatic logic [bldt_pkg::SEG_W-1:0] seg_for(int digit);
        return (digit <= 9) ? DIGIT_SEGS[digit] : '0;
    endfunction

    function automatic gauge_t advance_gauge(bldt_pkg::item_t r);
        gauge_t g;
        int mv, lvl, old_lvl, meas_lvl, ft, st, period;
        int empty_mv, knee_mv;
        mv       = r.supply_millivolts;
        empty_mv = tracker_cfg.empty_mv;
        knee_mv  = tracker_cfg.knee_mv;
        lvl      = shown_state;
        old_lvl  = lvl;
        ft       = full_ticks;
        st       = slew_ticks;
        if (r.low_lock)
        begin
            lvl = 0;
            measured_state = '0;
            lock_count++;
        end
        else if (mv < empty_mv)
        begin
            empty_count++;
            // Ten-second marks walk the level down to 1, but never while charging.
            if (r.ten_second_mark)
            begin
                if (lvl > 1)
                begin
                    if (!r.charging)
                        lvl--;
                end
                else
                begin
                    lvl = 1;
                end
            end
            measured_state = bldt_pkg::EMPTY_LEVEL;
        end
        else
        begin
            if (mv < knee_mv)
                meas_lvl = (mv - empty_mv) / LOW_MV_PER_LEVEL;
            else
                meas_lvl = int'(bldt_pkg::KNEE_LEVEL) + (mv - knee_mv) / HIGH_MV_PER_LEVEL;
            if (meas_lvl > int'(bldt_pkg::LEVEL_MAX))
                meas_lvl = int'(bldt_pkg::LEVEL_MAX);
            measured_state = meas_lvl[bldt_pkg::LVL_W-1:0];
            if (r.charging)
            begin
                if (r.charge_full && lvl < int'(bldt_pkg::LEVEL_MAX))
                begin
                    if (ft + 1 >= int'(tracker_cfg.full_rise))
                    begin
                        ft = 0;
                        lvl++;
                    end
                    else
                    begin
                        ft = ft + 1;
                    end
                end
                else
                begin
                    ft = 0;
                end
                // The charge slew compares against the level after the full rise.
                if (meas_lvl > lvl)
                begin
                    if (st + 1 >= int'(tracker_cfg.charge_rise)
                        && lvl < int'(bldt_pkg::LEVEL_MAX))
                    begin
                        st = 0;
                        lvl++;
                    end
                    else
                    begin
                        st = (st + 1) & PERIOD_TOP;
                    end
                end
                else
                begin
                    st = 0;
                end
            end
            else
            begin
                period = (lvl < int'(tracker_cfg.fast_fall_below)) ?
                         int'(tracker_cfg.fast_fall) : int'(tracker_cfg.slow_fall);
                if (meas_lvl < lvl && lvl > 1)
                begin
                    if (st + 1 >= period)
                    begin
                        st = 0;
                        lvl--;
                    end
                    else
                    begin
                        st = st + 1;
                    end
                end
                else
                begin
                    st = 0;
                end
            end
        end
        if (lvl > old_lvl)
            rise_count++;
        else if (lvl < old_lvl && !r.low_lock)
            fall_count++;
        shown_state = lvl[bldt_pkg::LVL_W-1:0];
        full_ticks  = ft[bldt_pkg::CNT_W-1:0];
        slew_ticks  = st[bldt_pkg::CNT_W-1:0];
        g.shown     = shown_state;
        g.measured  = measured_state;
        g.tens      = seg_for(lvl / 10);
        g.ones      = seg_for(lvl % 10);
        return g;
    endfunction

    function automatic bldt_pkg::item_t make_reading(int mv, bit chg, bit full, bit lock,
                                                     bit mark);
        bldt_pkg::item_t r;
        r.supply_millivolts = mv[bldt_pkg::MV_W-1:0];
        r.charging          = chg;
        r.charge_full       = full;
        r.low_lock          = lock;
        r.ten_second_mark   = mark;
        return r;
    endfunction

    function automatic int supply_near(int lo, int hi);
        if (lo < 0)
            lo = 0;
        if (hi > MV_TOP)
            hi = MV_TOP;
        if (hi < lo)
            return lo > MV_TOP ? MV_TOP : lo;
        return $urandom_range(hi, lo);
    endfunction

    task automatic report_mismatch(string field, int got, int want);
        mismatches++;
        // Keep the log readable if the block is badly broken.
        if (mismatches <= MAX_PRINTED)
            $display("%0t: word %0d %s: got %0d, expected %0d",
                     $realtime, words_checked, field, got, want);
    endtask

    // Sends one reading, holding valid across back-to-back words unless a random gap is put in first.
    task automatic send_reading(bldt_pkg::item_t r);
        if (gaps_on && $urandom_range(0, 3) == 0)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
        in_ch.valid             <= 1'b1;
        in_ch.supply_millivolts <= r.supply_millivolts;
        in_ch.charging          <= r.charging;
        in_ch.charge_full       <= r.charge_full;
        in_ch.low_lock          <= r.low_lock;
        in_ch.ten_second_mark   <= r.ten_second_mark;
        do
            @(posedge clk);
        while (!in_ch.ready);
        expected_gauges.push_back(advance_gauge(r));
        readings_sent++;
    endtask

    task automatic write_register(logic [bldt_pkg::IDX_W-1:0] idx,
                                  logic [bldt_pkg::DATA_W-1:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        case (idx)
            bldt_pkg::REG_EMPTY_MV:
                tracker_cfg.empty_mv = value[bldt_pkg::MV_W-1:0];
            bldt_pkg::REG_KNEE_MV:
                tracker_cfg.knee_mv = value[bldt_pkg::MV_W-1:0];
            bldt_pkg::REG_FULL_RISE:
                tracker_cfg.full_rise = value[bldt_pkg::CNT_W-1:0];
            bldt_pkg::REG_CHARGE_RISE:
                tracker_cfg.charge_rise = value[bldt_pkg::CNT_W-1:0];
            bldt_pkg::REG_SLOW_FALL:
                tracker_cfg.slow_fall = value[bldt_pkg::CNT_W-1:0];
            bldt_pkg::REG_FAST_FALL:
                tracker_cfg.fast_fall = value[bldt_pkg::CNT_W-1:0];
            bldt_pkg::REG_FAST_FALL_BELOW:
                tracker_cfg.fast_fall_below = value[bldt_pkg::LVL_W-1:0];
            default: ;
        endcase
        cfg_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    // Upper data bits beyond each register's width are filled at random.
    task automatic configure_tracker(int empty_mv, int knee_mv, int full_rise, int charge_rise,
                                     int slow_fall, int fast_fall, int fall_below);
        write_register(bldt_pkg::REG_EMPTY_MV,
                       14'(empty_mv) | (14'($urandom_range(0, 1)) << bldt_pkg::MV_W));
        write_register(bldt_pkg::REG_KNEE_MV,
                       14'(knee_mv) | (14'($urandom_range(0, 1)) << bldt_pkg::MV_W));
        write_register(bldt_pkg::REG_FULL_RISE, 14'(full_rise));
        write_register(bldt_pkg::REG_CHARGE_RISE, 14'(charge_rise));
        write_register(bldt_pkg::REG_SLOW_FALL, 14'(slow_fall));
        write_register(bldt_pkg::REG_FAST_FALL, 14'(fast_fall));
        write_register(bldt_pkg::REG_FAST_FALL_BELOW,
                       14'(fall_below) | (14'($urandom_range(0, 127)) << bldt_pkg::LVL_W));
        settings_used++;
    endtask

    task automatic wait_for_results();
        in_ch.valid <= 1'b0;
        while (expected_gauges.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Mostly well-formed charge, discharge and empty runs, with some lockout and noise.
    task automatic run_readings(int count);
        int  done, kind, len, k, base, mv, drop;
        bit  full_run;
        done = 0;
        while (done < count)
        begin
            kind     = $urandom_range(0, 9);
            len      = $urandom_range(4, 30);
            full_run = $urandom_range(0, 1);
            base     = supply_near(int'(tracker_cfg.knee_mv) - 200,
                                   int'(tracker_cfg.knee_mv) + 500);
            drop     = $urandom_range(0, 40);
            for (k = 0; k < len && done < count; k++)
            begin
                case (kind)
                    0, 1, 2:
                    begin
                        mv = supply_near(int'(tracker_cfg.knee_mv) - 100,
                                         int'(tracker_cfg.knee_mv) + 500);
                        send_reading(make_reading(mv, 1'b1, full_run,
                                                  $urandom_range(0, 39) == 0,
                                                  $urandom_range(0, 9) == 0));
                    end
                    3, 4, 5:
                    begin
                        mv = base - k * drop;
                        send_reading(make_reading(mv < 0 ? 0 : mv, 1'b0, $urandom_range(0, 1),
                                                  $urandom_range(0, 39) == 0,
                                                  $urandom_range(0, 5) == 0));
                    end
                    6, 7:
                    begin
                        mv = (tracker_cfg.empty_mv == 0) ? 0 :
                             $urandom_range(int'(tracker_cfg.empty_mv) - 1, 0);
                        send_reading(make_reading(mv, $urandom_range(0, 3) == 0,
                                                  $urandom_range(0, 1), 1'b0,
                                                  $urandom_range(0, 1)));
                    end
                    8:
                    begin
                        send_reading(make_reading($urandom_range(MV_TOP, 0), $urandom_range(0, 1),
                                                  $urandom_range(0, 1), 1'b1,
                                                  $urandom_range(0, 1)));
                    end
                    default:
                    begin
                        send_reading(make_reading($urandom_range(MV_TOP, 0), $urandom_range(0, 1),
                                                  $urandom_range(0, 1), $urandom_range(0, 7) == 0,
                                                  $urandom_range(0, 1)));
                    end
                endcase
                done++;
            end
        end
    endtask

    // Voltage mapping edges with the register defaults left in place.
    task automatic test_level_mapping();
        send_reading(make_reading(MV_TOP, 1'b1, 1'b1, 1'b1, 1'b1));
        send_reading(make_reading(0, 1'b0, 1'b0, 1'b0, 1'b1));
        send_reading(make_reading(2799, 1'b0, 1'b0, 1'b0, 1'b0));
        send_reading(make_reading(2800, 1'b0, 1'b0, 1'b0, 1'b0));
        send_reading(make_reading(3599, 1'b0, 1'b0, 1'b0, 1'b0));
        send_reading(make_reading(3600, 1'b1, 1'b0, 1'b0, 1'b0));
        send_reading(make_reading(3995, 1'b1, 1'b0, 1'b0, 1'b0));
        send_reading(make_reading(MV_TOP, 1'b1, 1'b0, 1'b0, 1'b0));
    endtask

    // Short periods so that rises, falls, marks and the lockout all show within a few words.
    task automatic test_slew_steps();
        int k;
        wait_for_results();
        write_register(bldt_pkg::REG_FULL_RISE, 14'd1);
        write_register(bldt_pkg::REG_CHARGE_RISE, 14'd2);
        write_register(bldt_pkg::REG_SLOW_FALL, 14'd0);
        write_register(bldt_pkg::REG_FAST_FALL, 14'd1);
        for (k = 0; k < 5; k++)
            send_reading(make_reading(4000, 1'b1, 1'b1, 1'b0, 1'b0));
        send_reading(make_reading(3000, 1'b1, 1'b1, 1'b0, 1'b1));
        send_reading(make_reading(2000, 1'b1, 1'b0, 1'b0, 1'b1));
        send_reading(make_reading(2000, 1'b0, 1'b0, 1'b0, 1'b1));
        for (k = 0; k < 3; k++)
            send_reading(make_reading(3000, 1'b0, 1'b0, 1'b0, 1'b0));
        send_reading(make_reading(4000, 1'b0, 1'b1, 1'b1, 1'b0));
        send_reading(make_reading(2000, 1'b0, 1'b0, 1'b0, 1'b1));
    endtask

    task automatic test_register_settings();
        int p, e;
        for (p = 0; p < 8; p++)
        begin
            wait_for_results();
            case (p)
                0: configure_tracker(2800, 3600, $urandom_range(1, 12), $urandom_range(1, 12),
                                     $urandom_range(1, 12), $urandom_range(1, 12), 40);
                1: configure_tracker(0, 0, 0, 0, 0, 0, 0);
                2: configure_tracker(MV_TOP, MV_TOP, PERIOD_TOP, PERIOD_TOP, PERIOD_TOP,
                                     PERIOD_TOP, 99);
                3:
                begin
                    // Knee under the empty voltage, plus a write to an index with no register.
                    configure_tracker(3500, 3000, 1, 1, 1, 1, 127);
                    write_register(REG_UNUSED, 14'($urandom_range(PERIOD_TOP, 0)));
                end
                default:
                begin
                    e = $urandom_range(5000, 0);
                    configure_tracker(e, e + $urandom_range(1200, 0), $urandom_range(25, 0),
                                      $urandom_range(25, 0), $urandom_range(25, 0),
                                      $urandom_range(25, 0), $urandom_range(99, 0));
                end
            endcase
            run_readings(PHASE_READINGS);
        end
    endtask

    // Closing stretch at full rate on both sides.
    task automatic test_steady_flow();
        int e;
        wait_for_results();
        gaps_on   = 1'b0;
        stalls_on = 1'b0;
        e = $urandom_range(4000, 1000);
        configure_tracker(e, e + $urandom_range(900, 100), $urandom_range(8, 1),
                          $urandom_range(8, 1), $urandom_range(8, 1), $urandom_range(8, 1),
                          $urandom_range(99, 0));
        run_readings(PHASE_READINGS);
    endtask

    // Sink side: random stall bursts on ready.
    initial
    begin
        int stall_left;
        stall_left = 0;
        out_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (stalls_on && stall_left == 0 && $urandom_range(0, 5) == 0)
                stall_left = $urandom_range(1, 11);
            if (stall_left > 0)
            begin
                out_ch.ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin : check_words
        gauge_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (expected_gauges.size() == 0)
            begin
                report_mismatch("arrived with nothing expected, shown level",
                                out_ch.shown_level, 0);
            end
            else
            begin
                want = expected_gauges.pop_front();
                if (out_ch.shown_level !== want.shown)
                    report_mismatch("shown_level", out_ch.shown_level, want.shown);
                if (out_ch.measured_level !== want.measured)
                    report_mismatch("measured_level", out_ch.measured_level, want.measured);
                if (out_ch.tens_segments !== want.tens)
                    report_mismatch("tens_segments", out_ch.tens_segments, want.tens);
                if (out_ch.ones_segments !== want.ones)
                    report_mismatch("ones_segments", out_ch.ones_segments, want.ones);
            end
            words_checked++;
        end
    end

    initial
    begin
        #8_000_000;
        $display("battery_level_display_tracker regression: fail");
        $finish;
    end

    initial
    begin
        tracker_cfg.empty_mv        = bldt_pkg::RST_EMPTY_MV;
        tracker_cfg.knee_mv         = bldt_pkg::RST_KNEE_MV;
        tracker_cfg.full_rise       = bldt_pkg::RST_FULL_RISE;
        tracker_cfg.charge_rise     = bldt_pkg::RST_CHARGE_RISE;
        tracker_cfg.slow_fall       = bldt_pkg::RST_SLOW_FALL;
        tracker_cfg.fast_fall       = bldt_pkg::RST_FAST_FALL;
        tracker_cfg.fast_fall_below = bldt_pkg::RST_FAST_FALL_BELOW;
        shown_state    = '0;
        measured_state = '0;
        full_ticks     = '0;
        slew_ticks     = '0;

        rst_n                   <= 1'b0;
        in_ch.valid             <= 1'b0;
        in_ch.supply_millivolts <= '0;
        in_ch.charging          <= 1'b0;
        in_ch.charge_full       <= 1'b0;
        in_ch.low_lock          <= 1'b0;
        in_ch.ten_second_mark   <= 1'b0;
        cfg_ch.valid            <= 1'b0;
        cfg_ch.index            <= bldt_pkg::REG_EMPTY_MV;
        cfg_ch.data             <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_level_mapping();
        test_slew_steps();
        test_register_settings();
        test_steady_flow();
        wait_for_results();

        $display("Checked %0d words from %0d readings under %0d register settings.",
                 words_checked, readings_sent, settings_used);
        $display("Readings in lockout %0d, below empty %0d; level rose %0d times, fell %0d.",
                 lock_count, empty_count, rise_count, fall_count);
        if (mismatches == 0)
            $display("battery_level_display_tracker regression: pass");
        else
            $display("battery_level_display_tracker regression: fail");
        $finish;
    end

endmodule

/* filelist.f */
src/bldt_pkg.sv
src/bldt_if.sv
src/bldt_cfg_regs.sv
src/bldt_level_map.sv
src/bldt_tracker.sv
src/battery_level_display_tracker.sv
bench/tb.sv
